### hw/rtl/bcba_pkg.sv
// ----------------------------------------------------------------------------
// bcba_pkg
// Shared types and constants of the contiguous block allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcba_pkg;

  // occupancy bits held in one memory word
  localparam int SEG_W  = 16;
  localparam int SEG_SH = $clog2(SEG_W);

  // request and result field widths
  localparam int LEN_W = 11;
  localparam int BLK_W = 10;
  // free-run counter: below the request length plus one word of growth
  localparam int RUN_W = LEN_W + 1;

  localparam int DEF_BLOCKS   = 1024;
  localparam int DEF_RESERVED = 1;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_NOFIT = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_LOAD,
    ST_SWEEP,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic              hit;
    logic [SEG_SH-1:0] pos;
    logic [RUN_W-1:0]  run;
  } scan_res_t;

endpackage

`default_nettype wire

### hw/rtl/bitmap_contiguous_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_contiguous_block_allocator_unit
// First-fit contiguous block allocator over a one-bit-per-block map kept in
// a word-wide memory.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                               tuser
//  s_*       in   run_length[10:0] first_block[20:11] kind
//  m_*       out  run_start[9:0]                      status
//
//  allocate: scans map words up to the fit, then loads and sweeps the words
//  of the run before the result step; the map is read one word a cycle.
//  release: loads, sweeps the words covered, then the result; empty or
//  clipped-away releases go straight to the result. after reset a clearing
//  pass writes every map word; s_tready stays low until it ends. a stalled
//  result holds the block in its result step; one request is in work at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bitmap_contiguous_block_allocator_unit #(
  parameter int BLOCKS   = bcba_pkg::DEF_BLOCKS,
  parameter int RESERVED = bcba_pkg::DEF_RESERVED
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // run_length[10:0], first_block[20:11], zero
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // run_start[9:0], zero
  output logic        m_tuser    // status
);
  import bcba_pkg::*;

  localparam int NWORDS = (BLOCKS + SEG_W - 1) / SEG_W;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BW     = $clog2(NWORDS * SEG_W + 1);

  logic [SEG_W-1:0] mem [NWORDS];
  logic [SEG_W-1:0] rdata;
  logic [AW-1:0]    raddr;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [SEG_W-1:0] wdata;

  state_t state, state_next;

  logic [AW-1:0]    cur;
  logic [AW-1:0]    hlast;
  logic [RUN_W-1:0] run;
  logic [BW-1:0]    lo;
  logic [BW-1:0]    hi;
  logic             op;
  logic [LEN_W-1:0] len_r;
  logic             status_r;
  logic [BLK_W-1:0] start_r;

  logic             in_kind;
  logic [LEN_W-1:0] in_len;
  logic [BLK_W-1:0] in_first;
  logic             accept;
  logic             alloc_bad;
  logic             rel_skip;
  logic [LEN_W:0]   rel_sum;
  logic [BW-1:0]    rel_hi;

  logic [SEG_W-1:0] pad_used;
  logic [SEG_W-1:0] run_mask;
  logic [SEG_W-1:0] init_word;
  logic [BW-1:0]    hit_endp1;
  scan_res_t        scan;
  logic             out_free;

  assign in_len   = s_tdata[LEN_W-1:0];
  assign in_first = s_tdata[LEN_W+BLK_W-1:LEN_W];
  assign in_kind  = s_tuser;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign alloc_bad = (in_len == '0) || (32'(in_len) > BLOCKS);
  assign rel_skip  = (in_len == '0) || (32'(in_first) >= BLOCKS);
  assign rel_sum   = {1'b0, in_len} + (LEN_W + 1)'(in_first);
  assign rel_hi    = (32'(rel_sum) > BLOCKS) ? BW'(BLOCKS) : BW'(rel_sum);

  // per-bit masks of the word at cur
  always_comb begin
    for (int b = 0; b < SEG_W; b++) begin
      pad_used[b]  = (32'({cur, SEG_SH'(b)}) >= BLOCKS);
      run_mask[b]  = (BW'({cur, SEG_SH'(b)}) >= lo) && (BW'({cur, SEG_SH'(b)}) < hi);
      init_word[b] = (32'({cur, SEG_SH'(b)}) < RESERVED);
    end
  end

  bcba_word_scan u_scan (
    .used  (rdata | pad_used),
    .carry (run),
    .len   (len_r),
    .res   (scan)
  );

  assign hit_endp1 = BW'({cur, scan.pos}) + BW'(1);

  // memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (cur == AW'(NWORDS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_ALLOC) begin
            state_next = alloc_bad ? ST_RESULT : ST_SCAN;
          end else begin
            state_next = rel_skip ? ST_RESULT : ST_LOAD;
          end
        end
      end
      ST_SCAN: begin
        if (scan.hit)                        state_next = ST_LOAD;
        else if (cur == AW'(NWORDS - 1))     state_next = ST_RESULT;
      end
      ST_LOAD:  state_next = ST_SWEEP;
      ST_SWEEP: begin
        if (cur == hlast) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // outputs and memory control
  always_comb begin
    s_tready = 1'b0;
    raddr    = cur + AW'(1);
    we       = 1'b0;
    waddr    = cur;
    wdata    = init_word;
    unique case (state)
      ST_CLEAR: we = 1'b1;
      ST_IDLE: begin
        s_tready = 1'b1;
        raddr    = '0;
      end
      ST_SCAN: ;
      ST_LOAD: raddr = AW'(lo >> SEG_SH);
      ST_SWEEP: begin
        we    = 1'b1;
        wdata = (op == KIND_ALLOC) ? (rdata | run_mask) : (rdata & ~run_mask);
      end
      ST_RESULT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      cur      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_RESULT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          cur <= cur + AW'(1);
        end
        ST_IDLE: begin
          if (accept) begin
            op       <= in_kind;
            len_r    <= in_len;
            cur      <= '0;
            run      <= '0;
            start_r  <= '0;
            lo       <= BW'(in_first);
            hi       <= rel_hi;
            status_r <= (in_kind == KIND_ALLOC && alloc_bad) ? STATUS_NOFIT : STATUS_OK;
          end
        end
        ST_SCAN: begin
          if (scan.hit) begin
            lo      <= hit_endp1 - BW'(len_r);
            hi      <= hit_endp1;
            start_r <= BLK_W'(hit_endp1 - BW'(len_r));
          end else if (cur == AW'(NWORDS - 1)) begin
            status_r <= STATUS_NOFIT;
          end else begin
            run <= scan.run;
            cur <= cur + AW'(1);
          end
        end
        ST_LOAD: begin
          cur   <= AW'(lo >> SEG_SH);
          hlast <= AW'((hi - BW'(1)) >> SEG_SH);
        end
        ST_SWEEP: begin
          cur <= cur + AW'(1);
        end
        ST_RESULT: begin
          if (out_free) begin
            m_tuser  <= status_r;
            m_tdata  <= {(16 - BLK_W)'(0), start_r};
          end
        end
        default: ;
      endcase
    end
  end

  // a request always leaves the idle state
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("accepted request did not start work");

  // carried free run never reaches the request length without a hit
  a_scan_run_short: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (run < RUN_W'(len_r)))
    else $error("scan carry reached request length");

  // the sweep stays inside the run
  a_sweep_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> (cur <= hlast))
    else $error("sweep ran past the last word of the run");

  // a no-fit result carries a zero start block
  a_nofit_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == STATUS_NOFIT)) |-> (m_tdata == '0))
    else $error("no-fit result with nonzero start block");

  // a result is loaded only from the result step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_RESULT))
    else $error("result appeared outside the result step");

endmodule

`default_nettype wire

### hw/rtl/bcba_word_scan.sv
// ----------------------------------------------------------------------------
// bcba_word_scan
// Finds the first bit of one map word at which the free run reaches the
// requested length, given the free run carried in from lower words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcba_word_scan (
  input  logic [bcba_pkg::SEG_W-1:0] used,
  input  logic [bcba_pkg::RUN_W-1:0] carry,
  input  logic [bcba_pkg::LEN_W-1:0] len,
  output bcba_pkg::scan_res_t        res
);
  import bcba_pkg::*;

  logic [RUN_W-1:0] run_v [SEG_W];
  logic [SEG_W-1:0] hit_v;

  // free run ending at each bit: from the last used bit, or the carry
  always_comb begin
    for (int i = 0; i < SEG_W; i++) begin
      run_v[i] = carry + RUN_W'(i + 1);
      for (int j = 0; j <= i; j++) begin
        if (used[j]) begin
          run_v[i] = RUN_W'(i - j);
        end
      end
      hit_v[i] = (run_v[i] >= RUN_W'(len));
    end
  end

  always_comb begin
    res.hit = |hit_v;
    res.pos = '0;
    for (int i = SEG_W - 1; i >= 0; i--) begin
      if (hit_v[i]) begin
        res.pos = SEG_SH'(i);
      end
    end
    res.run = run_v[SEG_W-1];
  end

endmodule

`default_nettype wire
